// ===== rtl/mandelbrot_escape_shade_assert.svh =====
// Assertion macros of the escape-shade RTL, used by mes_ctrl.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef MANDELBROT_ESCAPE_SHADE_ASSERT_SVH
`define MANDELBROT_ESCAPE_SHADE_ASSERT_SVH

// Same-cycle implication.
`define MES_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mes_pkg.sv =====
// Types, constants and helpers of the escape-shade block.
// Used by mes_ctrl, mes_dpath and mandelbrot_escape_shade.
`timescale 1ns / 1ps
package mes_pkg;
	localparam int FRAC_BITS = 28;
	localparam int DIM_BITS  = 12;
	localparam int ITER_BITS = 16;
	localparam int SIZE_BITS = DIM_BITS + 1;
	localparam int CFG_W     = (SIZE_BITS > ITER_BITS) ? SIZE_BITS : ITER_BITS;
	localparam int SPAN_W    = FRAC_BITS + 2;
	localparam int DXY_W     = SPAN_W + DIM_BITS;
	localparam int DG_W      = ITER_BITS + 8;
	localparam int DIVN_W    = (DXY_W > DG_W) ? DXY_W : DG_W;
	localparam int DVS_W     = (DIM_BITS > ITER_BITS) ? DIM_BITS : ITER_BITS;
	localparam int CNT_W     = $clog2(DIVN_W + 1);

	localparam logic [SPAN_W-1:0] X_SPAN = SPAN_W'(64'd3 << FRAC_BITS);
	localparam logic [SPAN_W-1:0] Y_SPAN = SPAN_W'(((64'd24 << FRAC_BITS) + 64'd5) / 10);
	localparam logic signed [31:0] X_LOW = -32'sd1 * 32'(64'd2 << FRAC_BITS);
	localparam logic signed [31:0] Y_LOW = -32'sd1 * 32'(((64'd12 << FRAC_BITS) + 64'd5) / 10);
	localparam logic [64:0] LIMIT4 = 65'(65'd4 << (2 * FRAC_BITS));

	localparam logic [SIZE_BITS-1:0] W_RESET = SIZE_BITS'(160);
	localparam logic [SIZE_BITS-1:0] H_RESET = SIZE_BITS'(120);
	localparam logic [ITER_BITS-1:0] N_RESET = ITER_BITS'(64);

	localparam logic [1:0] REG_WIDTH    = 2'd0;
	localparam logic [1:0] REG_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_MAX_ITER = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_SETX, S_DIVX, S_SETY, S_DIVY, S_TEST, S_CHK, S_SETG, S_DIVG, S_DONE
	} state_t;

	typedef enum logic [1:0] {DIV_X, DIV_Y, DIV_G} div_sel_t;

	typedef struct packed {
		logic     start_in;
		logic     div_start;
		logic     div_run;
		logic     div_take;
		div_sel_t div_sel;
		logic     mul;
		logic     upd;
		logic     grey_zero;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic iter_full;
		logic escaped;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction
endpackage

// ===== rtl/mes_ctrl.sv =====
// Controller of the escape-shade block: sequences mapping, iteration and shading.
// Depends on mes_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "mandelbrot_escape_shade_assert.svh"
module mes_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output mes_pkg::cmd_t cmd,
	input  mes_pkg::sts_t sts
);
	import mes_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.div_sel = DIV_X;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start_in = 1'b1;
					state_d      = S_SETX;
				end
			end
			S_SETX: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVX;
			end
			S_DIVX: begin
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = S_SETY;
				end else cmd.div_run = 1'b1;
			end
			S_SETY: begin
				cmd.div_sel   = DIV_Y;
				cmd.div_start = 1'b1;
				state_d       = S_DIVY;
			end
			S_DIVY: begin
				cmd.div_sel = DIV_Y;
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = S_TEST;
				end else cmd.div_run = 1'b1;
			end
			S_TEST: begin
				if (sts.iter_full) begin
					cmd.grey_zero = 1'b1;
					state_d       = S_DONE;
				end else begin
					cmd.mul = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.escaped) state_d = S_SETG;
				else begin
					cmd.upd = 1'b1;
					state_d = S_TEST;
				end
			end
			S_SETG: begin
				cmd.div_sel   = DIV_G;
				cmd.div_start = 1'b1;
				state_d       = S_DIVG;
			end
			S_DIVG: begin
				cmd.div_sel = DIV_G;
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = S_DONE;
				end else cmd.div_run = 1'b1;
			end
			S_DONE: begin
				// wait until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	`MES_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready, out_valid_q, "result dropped")
	`MES_ASSERT_NOW(a_take_done, cmd.div_take, sts.div_done, "divider result taken early")
	`MES_ASSERT_NOW(a_upd_live, cmd.upd, !sts.iter_full && !sts.escaped, "update after end")
	`MES_ASSERT_NEXT(a_done_wait, state_q == S_DONE && out_valid_q && !out_ready,
		state_q == S_DONE, "result overwritten while stalled")
endmodule

// ===== rtl/mes_dpath.sv =====
// Datapath of the escape-shade block: registers, shared divider, iteration unit.
// Depends on mes_pkg; driven by mes_ctrl commands.
`timescale 1ns / 1ps
module mes_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [1:0]                     cfg_index,
	input  logic [mes_pkg::CFG_W-1:0]      cfg_data,
	input  logic [mes_pkg::DIM_BITS-1:0]   pixel_col,
	input  logic [mes_pkg::DIM_BITS-1:0]   pixel_row,
	input  mes_pkg::cmd_t                  cmd,
	output mes_pkg::sts_t                  sts,
	output logic [7:0]                     grey_level,
	output logic [mes_pkg::ITER_BITS-1:0]  iter_count
);
	import mes_pkg::*;

	logic [SIZE_BITS-1:0] width_q, height_q;
	logic [ITER_BITS-1:0] max_iter_q;
	logic [DIM_BITS-1:0]  col_q, row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= W_RESET;
			height_q   <= H_RESET;
			max_iter_q <= N_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:    width_q    <= SIZE_BITS'(cfg_data);
				REG_HEIGHT:   height_q   <= SIZE_BITS'(cfg_data);
				REG_MAX_ITER: max_iter_q <= ITER_BITS'(cfg_data);
				default: ;
			endcase
		end
	end

	// clamp coordinates; a size of zero counts as one
	logic [SIZE_BITS-1:0] w_eff, h_eff, w_lim, h_lim;
	logic [DIM_BITS-1:0]  col_c, row_c;
	assign w_eff = (width_q == '0) ? SIZE_BITS'(1) : width_q;
	assign h_eff = (height_q == '0) ? SIZE_BITS'(1) : height_q;
	assign w_lim = w_eff - SIZE_BITS'(1);
	assign h_lim = h_eff - SIZE_BITS'(1);
	assign col_c = ({1'b0, col_q} > w_lim) ? DIM_BITS'(w_lim) : col_q;
	assign row_c = ({1'b0, row_q} > h_lim) ? DIM_BITS'(h_lim) : row_q;

	logic [ITER_BITS-1:0] n_q;
	logic [DIVN_W-1:0]    dvd_in;
	logic [DVS_W-1:0]     dvs_in;
	always_comb begin
		case (cmd.div_sel)
			DIV_X: begin
				dvd_in = DIVN_W'(DXY_W'(X_SPAN) * DXY_W'(col_c));
				dvs_in = DVS_W'(w_lim);
			end
			DIV_Y: begin
				dvd_in = DIVN_W'(DXY_W'(Y_SPAN) * DXY_W'(row_c));
				dvs_in = DVS_W'(h_lim);
			end
			default: begin
				dvd_in = DIVN_W'({n_q, 8'd0} - DG_W'(n_q));
				dvs_in = DVS_W'(max_iter_q);
			end
		endcase
	end

	// restoring divider, one quotient bit per cycle
	logic [DIVN_W-1:0] dvd_q, quo_q;
	logic [DVS_W-1:0]  dvs_q, rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DVS_W:0]    trial;
	logic              fits;
	assign trial = {rem_q, dvd_q[DIVN_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (cmd.div_start) cnt_q <= CNT_W'(DIVN_W);
		else if (cmd.div_run && cnt_q != '0) cnt_q <= cnt_q - CNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q <= dvd_in;
			dvs_q <= dvs_in;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_run && cnt_q != '0) begin
			dvd_q <= {dvd_q[DIVN_W-2:0], 1'b0};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
			quo_q <= {quo_q[DIVN_W-2:0], fits};
		end
	end

	logic signed [31:0] cr_q, ci_q, zr_q, zi_q;
	logic signed [63:0] r2_q, i2_q, cross_q;
	logic [7:0]         grey_q;
	logic signed [31:0] q32;
	logic signed [63:0] nr, ni;
	assign q32 = 32'(quo_q);
	assign nr  = ((r2_q - i2_q) >>> FRAC_BITS) + 64'(cr_q);
	assign ni  = (cross_q >>> (FRAC_BITS - 1)) + 64'(ci_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) n_q <= '0;
		else if (cmd.start_in) n_q <= '0;
		else if (cmd.upd) n_q <= n_q + ITER_BITS'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.start_in) begin
			col_q <= pixel_col;
			row_q <= pixel_row;
			zr_q  <= '0;
			zi_q  <= '0;
		end
		if (cmd.div_take) begin
			case (cmd.div_sel)
				DIV_X:   cr_q   <= (w_eff <= SIZE_BITS'(1)) ? X_LOW : X_LOW + q32;
				DIV_Y:   ci_q   <= (h_eff <= SIZE_BITS'(1)) ? Y_LOW : Y_LOW + q32;
				default: grey_q <= 8'(8'd255 - 8'(quo_q));
			endcase
		end
		if (cmd.grey_zero) grey_q <= 8'd0;
		if (cmd.mul) begin
			r2_q    <= zr_q * zr_q;
			i2_q    <= zi_q * zi_q;
			cross_q <= zr_q * zi_q;
		end
		if (cmd.upd) begin
			zr_q <= sat32(nr);
			zi_q <= sat32(ni);
		end
		if (cmd.out_load) begin
			grey_level <= grey_q;
			iter_count <= n_q;
		end
	end

	assign sts.div_done  = (cnt_q == '0);
	assign sts.iter_full = (n_q >= max_iter_q);
	assign sts.escaped   = ({1'b0, r2_q} + {1'b0, i2_q}) > LIMIT4;
endmodule

// ===== rtl/mandelbrot_escape_shade.sv =====
// Top level of the Mandelbrot escape-time shader.
// Instantiates mes_ctrl and mes_dpath; depends on mes_pkg.
//
// Usage: a request on s_* carries one pixel (column, row). It is mapped onto
// the view rectangle, iterated z = z*z + c, and one result (grey shade and
// iteration count) leaves on m_*. The cfg channel writes image_width (0),
// image_height (1) and max_iter (2); cfg_ready is always high. The user must
// make writes only while the block is idle; the block does not enforce this.
// Steps: the shared divider maps the column, then the row, onto c; the escape
// loop then multiplies, and tests and updates z, once per iteration; a point
// that escapes is shaded by a third division, and one that reaches max_iter
// is shaded zero. The divider yields one quotient bit per cycle over a
// dividend of DIVN_W = 42 bits.
// One pixel is in work at a time; s_tready is high only when idle, so the next
// pixel is accepted only once the last result has moved to the output. The
// result waits in an output register, so the next pixel is taken while a
// stalled result is held; a new result waits until that register is free.
// Reset restores 160 x 120 and a limit of 64 and empties the output.
`timescale 1ns / 1ps
module mandelbrot_escape_shade (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [23:0]               s_tdata,   // pixel_col[11:0], pixel_row[23:12]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [23:0]               m_tdata,   // grey_level[7:0], iter_count[23:8]
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [mes_pkg::CFG_W-1:0] cfg_data
);
	import mes_pkg::*;

	cmd_t                 cmd;
	sts_t                 sts;
	logic [7:0]           grey;
	logic [ITER_BITS-1:0] count;

	assign cfg_ready = 1'b1;

	mes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	mes_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixel_col  (s_tdata[11:0]),
		.pixel_row  (s_tdata[23:12]),
		.cmd        (cmd),
		.sts        (sts),
		.grey_level (grey),
		.iter_count (count)
	);

	assign m_tdata = {count, grey};
endmodule

// ===== bench/tb_mandelbrot_escape_shade.sv =====
// Self-checking bench for mandelbrot_escape_shade: directed rows, then random pixels.
// Needs mes_pkg and the block's RTL; predicts each shade with its own escape loop.
`timescale 1ns / 1ps
module tb_mandelbrot_escape_shade;
	import mes_pkg::*;

	localparam int HANG_LIMIT = 600000;
	localparam int DRAIN_PAD  = 200;
	localparam int LONG_HOLD  = 2000;

	typedef enum logic {STEP_PIX, STEP_CFG} step_kind_t;

	typedef struct {
		step_kind_t          kind;
		logic [1:0]          idx;
		logic [CFG_W-1:0]    val;
		logic [DIM_BITS-1:0] col;
		logic [DIM_BITS-1:0] row;
		bit                  typed;
		logic [7:0]          grey;
		logic [ITER_BITS-1:0] iters;
	} step_t;

	typedef struct {
		bit                   typed;
		logic [7:0]           grey;
		logic [ITER_BITS-1:0] iters;
	} shade_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [23:0]          s_tdata;   // pixel_col[11:0], pixel_row[23:12]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [23:0]          m_tdata;   // grey_level[7:0], iter_count[23:8]
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [1:0]           cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	logic [SIZE_BITS-1:0] cur_w;
	logic [SIZE_BITS-1:0] cur_h;
	logic [ITER_BITS-1:0] cur_lim;

	step_t  plan[$];
	shade_t typed_q[$];
	shade_t shade_q[$];
	int     errors;
	int     pix_sent;
	int     shades_seen;
	int     idle_cycles;
	bit     quiet;
	bit     hold_req;

	mandelbrot_escape_shade u_top (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int clamp32(input longint x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return int'(x);
	endfunction

	// low edge plus floor(span*pos/(size-1)); sizes of zero and one pin to the low edge
	function automatic int map_axis(input longint lo, input longint unsigned span,
			input longint unsigned pos, input longint unsigned size);
		if (size < 1) size = 1;
		if (pos > size - 1) pos = size - 1;
		if (size <= 1) return clamp32(lo);
		return clamp32(lo + longint'((span * pos) / (size - 1)));
	endfunction

	function automatic shade_t shade_pixel(input logic [DIM_BITS-1:0] col,
			input logic [DIM_BITS-1:0] row);
		longint unsigned one;
		longint unsigned lim4;
		longint unsigned ar, ai, r2, i2;
		longint          prod_ri, diff;
		int              cr, ci, zr, zi;
		longint          n;
		shade_t          res;
		one  = 64'd1 << FRAC_BITS;
		lim4 = 64'd4 << (2 * FRAC_BITS);
		cr = map_axis(-longint'(2 * one), 3 * one, col, cur_w);
		ci = map_axis(-longint'((12 * one + 5) / 10), (24 * one + 5) / 10, row, cur_h);
		zr = 0;
		zi = 0;
		for (n = 0; n < cur_lim; n++) begin
			ar = (zr < 0) ? longint'(-longint'(zr)) : longint'(zr);
			ai = (zi < 0) ? longint'(-longint'(zi)) : longint'(zi);
			r2 = ar * ar;
			i2 = ai * ai;
			if (r2 + i2 > lim4) break;
			prod_ri = longint'(zr) * longint'(zi);
			diff    = longint'(r2) - longint'(i2);
			zi = clamp32((prod_ri >>> (FRAC_BITS - 1)) + ci);
			zr = clamp32((diff >>> FRAC_BITS) + cr);
		end
		res.typed = 1'b0;
		res.grey  = (n < cur_lim) ? 8'(255 - (n * 255) / cur_lim) : 8'd0;
		res.iters = ITER_BITS'(n);
		return res;
	endfunction

	task automatic report_miss(input string what, input int want, input int got);
		$display("mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
		errors++;
	endtask

	// scoreboard, config shadow and watchdog, all sampled at the rising edge
	always @(posedge clk) begin
		shade_t want, tv;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH:    cur_w = cfg_data[SIZE_BITS-1:0];
					REG_HEIGHT:   cur_h = cfg_data[SIZE_BITS-1:0];
					REG_MAX_ITER: cur_lim = cfg_data[ITER_BITS-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				want = shade_pixel(s_tdata[11:0], s_tdata[23:12]);
				tv = typed_q.pop_front();
				if (tv.typed) want = tv;
				shade_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				shades_seen++;
				if (shade_q.size() == 0) begin
					$display("unexpected shade at %0t: %h", $time, m_tdata);
					errors++;
				end else begin
					want = shade_q.pop_front();
					if (m_tdata[7:0] !== want.grey)
						report_miss("grey_level", want.grey, m_tdata[7:0]);
					if (m_tdata[23:8] !== want.iters)
						report_miss("iter_count", want.iters, m_tdata[23:8]);
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", HANG_LIMIT);
				$display("tb_mandelbrot_escape_shade: FAIL");
				$finish;
			end
		end
	end

	// receiver: short random stalls, one long hold-off on request, none when quiet
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 1'b0;
				m_tready = 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(0, 2)) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	task automatic drain;
		while (shade_q.size() != 0 || typed_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// optionally drop valid for a random while first, then hold the request until taken
	task automatic send_pixel(input logic [DIM_BITS-1:0] col, input logic [DIM_BITS-1:0] row,
			input shade_t tv);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		typed_q.push_back(tv);
		s_tvalid = 1'b1;
		s_tdata  = {row, col};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pix_sent++;
	endtask

	task automatic run_plan;
		step_t  st;
		shade_t tv;
		while (plan.size() != 0) begin
			st = plan.pop_front();
			if (st.kind == STEP_CFG) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				drain();
				repeat (DRAIN_PAD) @(posedge clk);
				write_reg(st.idx, st.val);
				@(negedge clk);
				cfg_valid = 1'b0;
			end else begin
				tv.typed = st.typed;
				tv.grey  = st.grey;
				tv.iters = st.iters;
				send_pixel(st.col, st.row, tv);
			end
		end
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	function automatic step_t cfg_step(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		step_t st;
		st = '{STEP_CFG, idx, val, '0, '0, 1'b0, '0, '0};
		return st;
	endfunction

	function automatic step_t pix_step(input int col, input int row, input bit typed,
			input int grey, input int iters);
		step_t st;
		st = '{STEP_PIX, '0, '0, DIM_BITS'(col), DIM_BITS'(row), typed, 8'(grey),
			ITER_BITS'(iters)};
		return st;
	endfunction

	initial begin
		int w, h, lim, nitems, col, row;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data  = '0;
		cur_w     = W_RESET;
		cur_h     = H_RESET;
		cur_lim   = N_RESET;
		errors = 0;
		pix_sent = 0;
		shades_seen = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset view: corner c = -2-1.2i escapes after one step
		plan.push_back(pix_step(0, 0, 1, 252, 1));
		plan.push_back(pix_step(4095, 4095, 0, 0, 0));
		plan.push_back(pix_step(107, 60, 0, 0, 0));
		plan.push_back(pix_step(80, 0, 0, 0, 0));
		plan.push_back(pix_step(159, 119, 0, 0, 0));
		// one-pixel image: everything lands on the low corner
		plan.push_back(cfg_step(REG_WIDTH, 1));
		plan.push_back(cfg_step(REG_HEIGHT, 1));
		plan.push_back(pix_step(0, 0, 1, 252, 1));
		plan.push_back(pix_step(4095, 4095, 1, 252, 1));
		// zero sizes act as one
		plan.push_back(cfg_step(REG_WIDTH, 0));
		plan.push_back(cfg_step(REG_HEIGHT, 0));
		plan.push_back(pix_step(5, 7, 1, 252, 1));
		// all data bits set: width masks to its field, unused index is dropped
		plan.push_back(cfg_step(REG_WIDTH, 16'hffff));
		plan.push_back(cfg_step(REG_HEIGHT, 4096));
		plan.push_back(cfg_step(2'd3, 16'hffff));
		plan.push_back(pix_step(4095, 2048, 0, 0, 0));
		plan.push_back(pix_step(2730, 0, 0, 0, 0));
		// zero limit: no iteration at all
		plan.push_back(cfg_step(REG_MAX_ITER, 0));
		plan.push_back(pix_step(100, 100, 1, 0, 0));
		// limit of one: corner never gets to escape
		plan.push_back(cfg_step(REG_MAX_ITER, 1));
		plan.push_back(pix_step(0, 0, 1, 0, 1));
		plan.push_back(pix_step(4095, 4095, 0, 0, 0));
		// largest limit: one fast escape and one point inside the set
		plan.push_back(cfg_step(REG_WIDTH, 160));
		plan.push_back(cfg_step(REG_HEIGHT, 120));
		plan.push_back(cfg_step(REG_MAX_ITER, 16'hffff));
		plan.push_back(pix_step(0, 0, 1, 255, 1));
		plan.push_back(pix_step(107, 60, 0, 0, 0));
		run_plan();

		for (int phase = 0; phase < 5; phase++) begin
			quiet = (phase == 4);
			case ($urandom_range(0, 5))
				0: w = 1;
				1: w = 4096;
				default: w = $urandom_range(2, 400);
			endcase
			case ($urandom_range(0, 5))
				0: h = 1;
				1: h = 4096;
				default: h = $urandom_range(2, 300);
			endcase
			case ($urandom_range(0, 9))
				0: lim = 0;
				1: lim = 1;
				2: lim = $urandom_range(150, 300);
				default: lim = $urandom_range(2, 100);
			endcase
			plan.push_back(cfg_step(REG_WIDTH, CFG_W'(w)));
			plan.push_back(cfg_step(REG_HEIGHT, CFG_W'(h)));
			plan.push_back(cfg_step(REG_MAX_ITER, CFG_W'(lim)));
			nitems = 100;
			for (int i = 0; i < nitems; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					col = $urandom_range(0, 4095);
					row = $urandom_range(0, 4095);
				end else begin
					col = $urandom_range(0, w - 1);
					row = $urandom_range(0, h - 1);
				end
				plan.push_back(pix_step(col, row, 0, 0, 0));
				if (phase == 1 && i == 40) begin
					run_plan();
					hold_req = 1'b1;
				end
				if (phase == 2 && i == 50) begin
					run_plan();
					drain();
				end
			end
			run_plan();
		end

		drain();
		repeat (DRAIN_PAD) @(posedge clk);
		$display("covered %0d pixels and %0d shades over sizes 0..8191 and limits 0..65535,",
			pix_sent, shades_seen);
		$display("with clamped coordinates, output stalls and one long back-pressure hold");
		if (errors == 0)
			$display("tb_mandelbrot_escape_shade: PASS");
		else
			$display("tb_mandelbrot_escape_shade: FAIL");
		$finish;
	end
endmodule
